### design/mtep_pkg.sv
// Shared types, status codes and result record of the MIDI track event parser.
`timescale 1ns / 1ps

package mtep_pkg;

  // Default width of the absolute tick counter.
  localparam int TIME_BITS_DEF = 32;

  // Width of the variable-length quantity accumulators.
  localparam int VLQ_BITS = 28;

  // Status bytes and meta types the parser acts on.
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
  localparam logic [7:0] ST_META      = 8'hFF;
  localparam logic [7:0] META_EOT     = 8'h2F;
  localparam logic [7:0] META_TEMPO   = 8'h51;

  // High nibbles of status bytes.
  localparam logic [3:0] HI_NOTE_OFF = 4'h8;
  localparam logic [3:0] HI_NOTE_ON  = 4'h9;
  localparam logic [3:0] HI_PROGRAM  = 4'hC;
  localparam logic [3:0] HI_CH_PRESS = 4'hD;
  localparam logic [3:0] HI_SYSTEM   = 4'hF;

  typedef enum logic [2:0] {
    PH_DELTA   = 3'd0,
    PH_STATUS  = 3'd1,
    PH_DATA1   = 3'd2,
    PH_DATA2   = 3'd3,
    PH_MTYPE   = 3'd4,
    PH_LEN     = 3'd5,
    PH_PAYLOAD = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    EV_NOTE  = 2'd0,
    EV_TEMPO = 2'd1,
    EV_END   = 2'd2
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t    event_kind;
    logic [7:0]  track_of_event;
    logic [31:0] abs_time;
    logic [3:0]  channel;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [23:0] tempo;
  } result_t;

endpackage

### design/mtep_parser.sv
// Byte-at-a-time track parser: state registers and the per-byte decode.
`timescale 1ns / 1ps

module mtep_parser
  import mtep_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       track_start,
  input  logic       last_byte,
  input  logic [7:0] track_id,
  output logic       res_valid,
  output result_t    res
);

  localparam int SUM_BITS = (TIME_BITS > VLQ_BITS) ? TIME_BITS : VLQ_BITS;
  localparam int ABS_BITS = (TIME_BITS > 32) ? TIME_BITS : 32;

  phase_t                 phase_r, phase_nxt;
  logic [7:0]             run_r, run_nxt;
  logic [7:0]             cur_r, cur_nxt;
  logic [VLQ_BITS-1:0]    delta_r, delta_nxt;
  logic [TIME_BITS-1:0]   time_r, time_nxt;
  logic [6:0]             first_r, first_nxt;
  logic [7:0]             meta_r, meta_nxt;
  logic [VLQ_BITS-1:0]    skip_r, skip_nxt;
  logic [23:0]            tempo_r, tempo_nxt;
  logic [1:0]             pos_r, pos_nxt;
  logic                   ended_r, ended_nxt;

  logic                   status_used;
  logic                   finish;
  logic [SUM_BITS-1:0]    time_sum;
  logic [ABS_BITS-1:0]    time_wide;
  logic [23:0]            tempo_aligned;

  always_comb begin
    // A track start clears everything before the byte is parsed.
    phase_nxt   = track_start ? PH_DELTA : phase_r;
    run_nxt     = track_start ? '0 : run_r;
    cur_nxt     = track_start ? '0 : cur_r;
    delta_nxt   = track_start ? '0 : delta_r;
    time_nxt    = track_start ? '0 : time_r;
    first_nxt   = track_start ? '0 : first_r;
    meta_nxt    = track_start ? '0 : meta_r;
    skip_nxt    = track_start ? '0 : skip_r;
    tempo_nxt   = track_start ? '0 : tempo_r;
    pos_nxt     = track_start ? '0 : pos_r;
    ended_nxt   = track_start ? 1'b0 : ended_r;
    status_used = 1'b0;
    finish      = 1'b0;
    time_sum    = '0;
    tempo_aligned = '0;
    res_valid   = 1'b0;
    res.event_kind     = EV_NOTE;
    res.track_of_event = track_id;
    res.note           = '0;
    res.velocity       = '0;
    res.tempo          = '0;

    if (!ended_nxt) begin
      if (phase_nxt == PH_STATUS) begin
        if (data_byte[7]) begin
          status_used = 1'b1;
          cur_nxt     = data_byte;
          if (data_byte[7:4] != HI_SYSTEM) begin
            run_nxt   = data_byte;
            phase_nxt = PH_DATA1;
          end else if (data_byte == ST_SYSEX || data_byte == ST_SYSEX_ESC) begin
            skip_nxt  = '0;
            phase_nxt = PH_LEN;
          end else if (data_byte == ST_META) begin
            phase_nxt = PH_MTYPE;
          end else begin
            phase_nxt = PH_DELTA;
          end
        end else if (run_nxt[7]) begin
          // Running status: this byte is the first data byte.
          cur_nxt   = run_nxt;
          phase_nxt = PH_DATA1;
        end else begin
          // No running status yet: the byte is read again as delta time.
          cur_nxt   = '0;
          phase_nxt = PH_DELTA;
        end
      end

      if (!status_used) begin
        unique case (phase_nxt)
          PH_DATA1: begin
            if (cur_nxt[7:4] == HI_PROGRAM || cur_nxt[7:4] == HI_CH_PRESS) begin
              phase_nxt = PH_DELTA;
            end else begin
              first_nxt = data_byte[6:0];
              phase_nxt = PH_DATA2;
            end
          end
          PH_DATA2: begin
            phase_nxt = PH_DELTA;
            if (cur_nxt[7:4] == HI_NOTE_OFF) begin
              res_valid = 1'b1;
              res.note  = first_nxt;
            end else if (cur_nxt[7:4] == HI_NOTE_ON) begin
              res_valid    = 1'b1;
              res.note     = first_nxt;
              res.velocity = data_byte[6:0];
            end
          end
          PH_MTYPE: begin
            meta_nxt  = data_byte;
            skip_nxt  = '0;
            phase_nxt = PH_LEN;
          end
          PH_LEN: begin
            skip_nxt = {skip_nxt[VLQ_BITS-8:0], data_byte[6:0]};
            if (!data_byte[7]) begin
              tempo_nxt = '0;
              pos_nxt   = '0;
              if (skip_nxt == '0) begin
                finish = 1'b1;
              end else begin
                phase_nxt = PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            if (cur_nxt == ST_META && meta_nxt == META_TEMPO && pos_nxt != 2'd3) begin
              tempo_nxt = {tempo_nxt[15:0], data_byte};
              pos_nxt   = pos_nxt + 2'd1;
            end
            skip_nxt = skip_nxt - VLQ_BITS'(1);
            if (skip_nxt == '0) begin
              finish = 1'b1;
            end
          end
          default: begin
            delta_nxt = {delta_nxt[VLQ_BITS-8:0], data_byte[6:0]};
            if (!data_byte[7]) begin
              time_sum  = SUM_BITS'(time_nxt) + SUM_BITS'(delta_nxt);
              time_nxt  = time_sum[TIME_BITS-1:0];
              delta_nxt = '0;
              phase_nxt = PH_STATUS;
            end else begin
              phase_nxt = PH_DELTA;
            end
          end
        endcase
      end

      if (finish) begin
        phase_nxt = PH_DELTA;
        if (cur_nxt == ST_META) begin
          if (meta_nxt == META_EOT) begin
            res_valid      = 1'b1;
            res.event_kind = EV_END;
            ended_nxt      = 1'b1;
          end else if (meta_nxt == META_TEMPO) begin
            // A short tempo payload counts its missing bytes as low-order zeros.
            unique case (pos_nxt)
              2'd0:    tempo_aligned = '0;
              2'd1:    tempo_aligned = {tempo_nxt[7:0], 16'h0000};
              2'd2:    tempo_aligned = {tempo_nxt[15:0], 8'h00};
              default: tempo_aligned = tempo_nxt;
            endcase
            res_valid      = 1'b1;
            res.event_kind = EV_TEMPO;
            res.tempo      = tempo_aligned;
          end
        end
      end
    end

    if (last_byte) begin
      ended_nxt = 1'b1;
    end

    time_wide    = ABS_BITS'(time_nxt);
    res.abs_time = time_wide[31:0];
    res.channel  = cur_nxt[3:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DELTA;
      run_r   <= '0;
      cur_r   <= '0;
      delta_r <= '0;
      time_r  <= '0;
      first_r <= '0;
      meta_r  <= '0;
      skip_r  <= '0;
      tempo_r <= '0;
      pos_r   <= '0;
      ended_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      run_r   <= run_nxt;
      cur_r   <= cur_nxt;
      delta_r <= delta_nxt;
      time_r  <= time_nxt;
      first_r <= first_nxt;
      meta_r  <= meta_nxt;
      skip_r  <= skip_nxt;
      tempo_r <= tempo_nxt;
      pos_r   <= pos_nxt;
      ended_r <= ended_nxt;
    end
  end

endmodule

### design/mtep_out_buf.sv
// Result register with a skid stage so the input side keeps moving under stall.
`timescale 1ns / 1ps

module mtep_out_buf
  import mtep_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    out_valid_r;
  logic    skid_valid_r;
  result_t out_data_r;
  result_t skid_data_r;

  assign space     = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

endmodule

### design/midi_track_event_parser_core.sv
// Top level of the MIDI track event parser: stream ports, parser and result buffer.
`timescale 1ns / 1ps

// Channel  Direction  Payload
// in_      slave      tdata[7:0] data byte, tdata[15:8] track id, tuser track start,
//                     tlast last byte of the track data
// out_     master     tuser event kind, tdata packed result fields (see port list)
//
// One track byte is taken per cycle while in_tready is high; its result, if any,
// is registered in the result register, or in the skid stage while the result
// side stalls. The parser state registers are the only loop; each byte updates them.
// Reset (rst_n low at a rising edge) clears the parser and empties the buffer.
// While the result side stalls, a skid stage holds one more result; in_tready
// drops only once both the result register and the skid stage are full.

module midi_track_event_parser_core
  import mtep_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] data_byte, [15:8] track_id
  input  logic        in_tuser,   // [0] track_start
  input  logic        in_tlast,   // last_byte

  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] track_of_event, [39:8] abs_time, [43:40] channel, [50:44] note,
  // [57:51] velocity, [81:58] tempo, [87:82] zero
  output logic [87:0] out_tdata,
  output logic [1:0]  out_tuser   // [1:0] event_kind
);

  logic    in_xfer;
  logic    res_valid;
  result_t res;
  logic    buf_space;
  result_t out_res;

  assign in_tready = buf_space;
  assign in_xfer   = in_tvalid && in_tready;

  // The parser decodes the byte straight from the input ports; a transfer
  // advances its state and, for a completed event, writes one result.
  mtep_parser #(
    .TIME_BITS (TIME_BITS)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_xfer),
    .data_byte   (in_tdata[7:0]),
    .track_start (in_tuser),
    .last_byte   (in_tlast),
    .track_id    (in_tdata[15:8]),
    .res_valid   (res_valid),
    .res         (res)
  );

  mtep_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_xfer && res_valid),
    .push_data (res),
    .space     (buf_space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tuser = out_res.event_kind;
  assign out_tdata = {6'b000000, out_res.tempo, out_res.velocity, out_res.note,
                      out_res.channel, out_res.abs_time, out_res.track_of_event};

  // The skid stage only fills behind a held result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("skid stage full while the result register is empty");

  // Note results never carry a tempo.
  a_note_no_tempo: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == EV_NOTE |-> out_tdata[81:58] == 24'h000000)
    else $error("note result with a nonzero tempo");

  // Tempo and end results come only from meta events.
  a_meta_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != EV_NOTE
      |-> out_tdata[57:44] == 14'h0000 && out_tdata[43:40] == 4'hF)
    else $error("meta result with note data or a channel other than meta");

endmodule

### tb/midi_track_event_parser_core_test.sv
// Self-checking testbench for the MIDI track event parser: random and directed track streams.
`timescale 1ns / 1ps

module midi_track_event_parser_core_test;
  import mtep_pkg::*;

  // Cycle limit for the whole run.
  localparam int CYCLE_LIMIT = 200000;
  // The result side refuses transfers over this window so the skid stage fills up.
  localparam int HOLD_FROM = 600;
  localparam int HOLD_LEN = 300;
  localparam int RANDOM_BYTES = 950;
  // Cycles to wait after the last expected event.
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] trk;
    logic       start;
    logic       last;
  } track_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [7:0] data_byte, [15:8] track_id
  logic        in_tuser = 1'b0; // [0] track_start
  logic        in_tlast = 1'b0; // last_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [7:0] track_of_event, [39:8] abs_time, [43:40] channel, [50:44] note,
  // [57:51] velocity, [81:58] tempo, [87:82] zero
  logic [87:0] out_tdata;
  logic [1:0]  out_tuser;       // [1:0] event_kind

  midi_track_event_parser_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Bytes waiting to be offered, and the events the parser should report.
  track_item_t track_stream[$];
  logic [7:0]  track_body[$];
  result_t     due_events[$];

  int errors = 0;
  int bytes_sent = 0;
  int tracks_sent = 0;
  int notes_seen = 0;
  int tempos_seen = 0;
  int ends_seen = 0;

  logic [31:0] cycle_cnt = '0;
  logic        rx_hold = 1'b0;
  // Both sides run without idle cycles while bits 9:8 of the cycle count are zero.
  wire         no_idle = (cycle_cnt[9:8] == 2'b00);

  // ---------------------------------------------------------------------------
  // Parser predictor. It mirrors the byte-level state machine: delta-time
  // accumulation, running status, note and meta decoding and skipped payloads.
  // ---------------------------------------------------------------------------
  phase_t      ph;
  logic [7:0]  run_st;
  logic [7:0]  cur_st;
  logic [7:0]  meta_ty;
  logic [27:0] delta_acc;
  logic [27:0] len_left;
  logic [31:0] tick;
  logic [6:0]  first_d;
  logic [23:0] tempo_acc;
  logic [1:0]  tempo_pos;
  logic        ended;

  task automatic clear_parser();
    ph = PH_DELTA;
    run_st = '0;
    cur_st = '0;
    meta_ty = '0;
    delta_acc = '0;
    len_left = '0;
    tick = '0;
    first_d = '0;
    tempo_acc = '0;
    tempo_pos = '0;
    ended = 1'b0;
  endtask

  task automatic emit_event(input ev_kind_t kind, input logic [7:0] trk,
                            input logic [6:0] nt, input logic [6:0] vel,
                            input logic [23:0] tmp);
    result_t ev;
    ev.event_kind = kind;
    ev.track_of_event = trk;
    ev.abs_time = tick;
    ev.channel = cur_st[3:0];
    ev.note = nt;
    ev.velocity = vel;
    ev.tempo = tmp;
    due_events.push_back(ev);
  endtask

  // Closes a sysex or meta block; only end-of-track and set-tempo report.
  task automatic finish_block(input logic [7:0] trk);
    logic [23:0] tval;
    ph = PH_DELTA;
    if (cur_st == ST_META && meta_ty == META_EOT) begin
      emit_event(EV_END, trk, '0, '0, '0);
      ended = 1'b1;
    end else if (cur_st == ST_META && meta_ty == META_TEMPO) begin
      // A short payload leaves the missing low-order bytes at zero.
      tval = tempo_acc << (8 * (3 - int'(tempo_pos)));
      emit_event(EV_TEMPO, trk, '0, '0, tval);
    end
  endtask

  task automatic parse_track_byte(input logic [7:0] b, input logic start,
                                  input logic last, input logic [7:0] trk);
    logic       used;
    logic [3:0] hi;
    if (start)
      clear_parser();
    if (!ended) begin
      used = 1'b0;
      if (ph == PH_STATUS) begin
        if (b[7]) begin
          used = 1'b1;
          cur_st = b;
          if (b[7:4] != HI_SYSTEM) begin
            run_st = b;
            ph = PH_DATA1;
          end else if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
            len_left = '0;
            ph = PH_LEN;
          end else if (b == ST_META) begin
            ph = PH_MTYPE;
          end else begin
            // Other system statuses stand alone.
            ph = PH_DELTA;
          end
        end else if (run_st[7]) begin
          // Running status: this byte is already the first data byte.
          cur_st = run_st;
          ph = PH_DATA1;
        end else begin
          // No channel status seen yet, so the byte is read as delta time.
          cur_st = '0;
          ph = PH_DELTA;
        end
      end
      if (!used) begin
        hi = cur_st[7:4];
        case (ph)
          PH_DATA1: begin
            if (hi == HI_PROGRAM || hi == HI_CH_PRESS) begin
              ph = PH_DELTA;
            end else begin
              first_d = b[6:0];
              ph = PH_DATA2;
            end
          end
          PH_DATA2: begin
            ph = PH_DELTA;
            if (hi == HI_NOTE_OFF)
              emit_event(EV_NOTE, trk, first_d, '0, '0);
            else if (hi == HI_NOTE_ON)
              emit_event(EV_NOTE, trk, first_d, b[6:0], '0);
          end
          PH_MTYPE: begin
            meta_ty = b;
            len_left = '0;
            ph = PH_LEN;
          end
          PH_LEN: begin
            len_left = {len_left[20:0], b[6:0]};
            if (!b[7]) begin
              tempo_acc = '0;
              tempo_pos = '0;
              if (len_left == '0)
                finish_block(trk);
              else
                ph = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            if (cur_st == ST_META && meta_ty == META_TEMPO && tempo_pos < 2'd3) begin
              tempo_acc = {tempo_acc[15:0], b};
              tempo_pos = tempo_pos + 2'd1;
            end
            len_left = len_left - 28'd1;
            if (len_left == '0)
              finish_block(trk);
          end
          default: begin
            delta_acc = {delta_acc[20:0], b[6:0]};
            if (!b[7]) begin
              tick = tick + {4'd0, delta_acc};
              delta_acc = '0;
              ph = PH_STATUS;
            end else begin
              ph = PH_DELTA;
            end
          end
        endcase
      end
    end
    if (last)
      ended = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building.
  // ---------------------------------------------------------------------------

  // Queues the collected track body; the first byte carries the track start.
  task automatic play_body(input logic [7:0] trk, input logic mark_last,
                           input logic noisy_id);
    track_item_t it;
    for (int i = 0; i < track_body.size(); i++) begin
      it.data = track_body[i];
      it.trk = (noisy_id && $urandom_range(0, 29) == 0) ? 8'($urandom_range(0, 255)) : trk;
      it.start = (i == 0);
      it.last = mark_last && (i == track_body.size() - 1);
      track_stream.push_back(it);
    end
    bytes_sent += track_body.size();
    tracks_sent++;
  endtask

  // Variable-length quantity, high group first. Groups beyond the value are
  // padding; junk_top fills a fifth group with bits the 28-bit limit drops.
  task automatic put_vlq(input logic [27:0] v, input int n_min, input logic junk_top);
    int         n;
    logic [6:0] g;
    n = 1;
    while (n < 4 && (v >> (7 * n)) != 0)
      n++;
    if (n < n_min)
      n = n_min;
    for (int i = n - 1; i >= 0; i--) begin
      g = (i >= 4) ? (junk_top ? 7'($urandom_range(0, 127)) : 7'd0) : 7'(v >> (7 * i));
      track_body.push_back({(i != 0), g});
    end
  endtask

  function automatic logic [7:0] data_value(input logic may_set_top);
    if (may_set_top && $urandom_range(0, 9) == 0)
      return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 127));
  endfunction

  task automatic put_delta(input logic big);
    logic [27:0] d;
    int          r;
    r = $urandom_range(0, 99);
    if (big)
      d = 28'($urandom_range(32'h0800_0000, 32'h0FFF_FFFF));
    else if (r < 60)
      d = 28'($urandom_range(0, 127));
    else if (r < 90)
      d = 28'($urandom_range(0, 16383));
    else
      d = 28'($urandom_range(0, 2097151));
    if ($urandom_range(0, 19) == 0)
      put_vlq(d, 5, 1'b1);
    else
      put_vlq(d, 1, 1'b0);
  endtask

  // Length (sometimes with zero padding groups) followed by a random payload.
  task automatic put_block(input int len);
    put_vlq(28'(len), ($urandom_range(0, 9) == 0) ? 2 : 1, 1'b0);
    for (int i = 0; i < len; i++)
      track_body.push_back(8'($urandom_range(0, 255)));
  endtask

  // One random event after its delta time. Running status is tracked so that
  // most sequences stay well formed.
  task automatic put_event(input logic big, inout logic have_run, inout logic [3:0] run_hi);
    int         r;
    logic [3:0] hi;
    logic [7:0] st;
    put_delta(big);
    r = $urandom_range(0, 99);
    if (r < 55) begin
      if (have_run && $urandom_range(0, 1) == 1) begin
        hi = run_hi;
        // Without a status byte the first data byte must look like data.
        track_body.push_back(data_value(1'b0));
      end else begin
        if (r < 40)
          hi = ($urandom_range(0, 1) == 1) ? HI_NOTE_ON : HI_NOTE_OFF;
        else
          hi = 4'($urandom_range(10, 14));
        track_body.push_back({hi, 4'($urandom_range(0, 15))});
        have_run = 1'b1;
        run_hi = hi;
        track_body.push_back(data_value(1'b1));
      end
      if (hi != HI_PROGRAM && hi != HI_CH_PRESS)
        track_body.push_back(($urandom_range(0, 7) == 0) ? 8'd0 : data_value(1'b1));
    end else if (r < 63) begin
      track_body.push_back(($urandom_range(0, 1) == 1) ? ST_SYSEX : ST_SYSEX_ESC);
      put_block($urandom_range(0, 6));
    end else if (r < 75) begin
      track_body.push_back(ST_META);
      track_body.push_back(META_TEMPO);
      put_block(($urandom_range(0, 3) != 0) ? 3 : $urandom_range(0, 5));
    end else if (r < 85) begin
      st = 8'($urandom_range(0, 255));
      if (st == META_EOT || st == META_TEMPO)
        st = 8'h01;
      track_body.push_back(ST_META);
      track_body.push_back(st);
      put_block($urandom_range(0, 4));
    end else if (r < 92) begin
      st = 8'($urandom_range(8'hF1, 8'hFE));
      if (st == ST_SYSEX_ESC)
        st = 8'hF8;
      track_body.push_back(st);
    end else begin
      // Line noise: a few arbitrary bytes that may break the framing.
      repeat ($urandom_range(1, 3))
        track_body.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic put_end_of_track(input logic big);
    put_delta(big);
    track_body.push_back(ST_META);
    track_body.push_back(META_EOT);
    put_block(($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0);
  endtask

  task automatic random_track();
    logic [7:0] trk;
    logic       big;
    logic       have_run;
    logic [3:0] run_hi;
    int         ending;
    track_body.delete();
    trk = 8'($urandom_range(0, 255));
    // Some tracks use huge deltas so that absolute time wraps around.
    big = ($urandom_range(0, 3) == 0);
    have_run = 1'b0;
    run_hi = HI_NOTE_ON;
    repeat ($urandom_range(2, 30))
      put_event(big, have_run, run_hi);
    ending = $urandom_range(0, 9);
    if (ending <= 6) begin
      put_end_of_track(big);
      // Bytes after end of track inside the same track are ignored.
      if (ending == 6)
        repeat ($urandom_range(1, 3))
          track_body.push_back(8'($urandom_range(0, 255)));
    end else if (ending <= 8) begin
      // The final event is cut short by the last byte.
      put_event(big, have_run, run_hi);
      repeat ($urandom_range(1, 3))
        if (track_body.size() > 1)
          void'(track_body.pop_back());
    end
    play_body(trk, (ending != 9), 1'b1);
    // Stray bytes before the next track start.
    if ($urandom_range(0, 4) == 0) begin
      track_body.delete();
      repeat ($urandom_range(1, 2))
        track_body.push_back(8'($urandom_range(0, 255)));
      for (int i = 0; i < track_body.size(); i++)
        track_stream.push_back('{data: track_body[i], trk: trk, start: 1'b0, last: 1'b0});
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender: offers queued bytes, with a random gap after each transfer.
  // ---------------------------------------------------------------------------
  int tx_gap = 0;

  always @(posedge clk) begin
    track_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (tx_gap != 0) begin
        in_tvalid <= 1'b0;
        tx_gap <= tx_gap - 1;
      end else if (track_stream.size() != 0) begin
        nxt = track_stream.pop_front();
        in_tdata <= {nxt.trk, nxt.data};
        in_tuser <= nxt.start;
        in_tlast <= nxt.last;
        in_tvalid <= 1'b1;
        tx_gap <= no_idle ? 0 : $urandom_range(0, 3);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: after each transfer it stays away for a random wait, and it
  // refuses every transfer while the long hold is on.
  // ---------------------------------------------------------------------------
  int rx_wait = 0;

  always @(posedge clk) begin
    int w;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait <= 0;
    end else if (rx_hold) begin
      out_tready <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      w = no_idle ? 0 : $urandom_range(0, 3);
      out_tready <= (w == 0);
      rx_wait <= w;
    end else if (!out_tready) begin
      if (rx_wait <= 1) begin
        out_tready <= 1'b1;
        rx_wait <= 0;
      end else begin
        rx_wait <= rx_wait - 1;
      end
    end
  end

  // Cycle count: drives the long hold window and the timeout.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 32'd1;
    rx_hold <= (cycle_cnt >= HOLD_FROM) && (cycle_cnt < HOLD_FROM + HOLD_LEN);
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d events still due",
               $time, cycle_cnt, due_events.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Checker. Results are compared before the byte of the same edge is
  // predicted, since a result never shows in the cycle of its own byte.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (due_events.size() == 0) begin
          errors++;
          $display("%0t: unexpected event: expected none, got kind %0d data %h",
                   $time, out_tuser, out_tdata);
        end else begin
          want = due_events.pop_front();
          check_field("event_kind", 32'(want.event_kind), 32'(out_tuser));
          check_field("track_of_event", 32'(want.track_of_event), 32'(out_tdata[7:0]));
          check_field("abs_time", want.abs_time, out_tdata[39:8]);
          check_field("channel", 32'(want.channel), 32'(out_tdata[43:40]));
          check_field("note", 32'(want.note), 32'(out_tdata[50:44]));
          check_field("velocity", 32'(want.velocity), 32'(out_tdata[57:51]));
          check_field("tempo", 32'(want.tempo), 32'(out_tdata[81:58]));
          case (want.event_kind)
            EV_NOTE:  notes_seen++;
            EV_TEMPO: tempos_seen++;
            default:  ends_seen++;
          endcase
        end
      end
      if (in_tvalid && in_tready)
        parse_track_byte(in_tdata[7:0], in_tuser, in_tlast, in_tdata[15:8]);
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: build all stimulus, release reset, wait for the drain.
  // ---------------------------------------------------------------------------
  initial begin
    clear_parser();

    // Directed track: note-on with top data bits set, running status,
    // note-off, pitch bend, program change, lone system status, short tempo
    // payload, end of track with a payload, then a byte after the end.
    track_body = '{8'h00, 8'h9F, 8'hFF, 8'h80,
                   8'h00, 8'h3C, 8'h40,
                   8'h00, 8'h8A, 8'h00, 8'h7F,
                   8'h00, 8'hE3, 8'h12, 8'h34,
                   8'h00, 8'hC5, 8'h07,
                   8'h81, 8'h00, 8'hF8,
                   8'h00, ST_META, META_TEMPO, 8'h02, 8'h07, 8'hA1,
                   8'h00, ST_META, META_EOT, 8'h01, 8'h55,
                   8'h00};
    play_body(8'hFF, 1'b1, 1'b0);
    // Data byte with no running status yet, then a note cut short.
    track_body = '{8'h00, 8'h05, 8'h90, 8'h3C};
    play_body(8'h00, 1'b1, 1'b0);

    while (bytes_sent < RANDOM_BYTES)
      random_track();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (track_stream.size() != 0 || in_tvalid)
      @(posedge clk);
    while (due_events.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d track bytes in %0d tracks over %0d cycles.",
             bytes_sent, tracks_sent, cycle_cnt);
    $display("Checked %0d note, %0d tempo and %0d end-of-track events, %0d errors.",
             notes_seen, tempos_seen, ends_seen, errors);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
